// File: rtl/dcs_pkg.sv
// Package for the dataflash command sequencer: field widths, opcodes,
// status codes, controller states and the controller/datapath structs.
// No dependencies.
package dcs_pkg;

  // Default sizing
  localparam int DCS_FLASH_PAGES = 8192;
  localparam int DCS_MAX_LENGTH  = 16384;

  // Payload widths
  localparam int ADDR_W = 24;
  localparam int LEN_W  = 15;
  localparam int STS_W  = 2;
  localparam int OP_W   = 8;
  localparam int POFF_W = 11;

  // Page sizes
  localparam logic [POFF_W-1:0] PSZ_1024 = 11'd1024;
  localparam logic [POFF_W-1:0] PSZ_1056 = 11'd1056;

  // Flash opcodes
  localparam logic [OP_W-1:0] OP_NONE      = 8'h00;
  localparam logic [OP_W-1:0] OP_FAST_READ = 8'h0B;
  localparam logic [OP_W-1:0] OP_BUF_WRITE = 8'h84;
  localparam logic [OP_W-1:0] OP_PAGE_TO_B = 8'h53;
  localparam logic [OP_W-1:0] OP_B_TO_PAGE = 8'h83;
  localparam logic [OP_W-1:0] OP_REFRESH   = 8'h58;

  // Result status codes
  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

  // Frame kinds loaded into the output register
  typedef enum logic [2:0] {
    FRM_STATUS,
    FRM_READ,
    FRM_PRE,
    FRM_WRITE,
    FRM_PROG,
    FRM_REFRESH
  } frame_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_STATUS,
    ST_READ,
    ST_PRE,
    ST_WRITE,
    ST_PROG,
    ST_REFRESH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic   load;
    logic   check;
    logic   div_step;
    logic   emit;
    frame_t frame;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic bad_addr;
    logic empty_len;
    logic is_write;
    logic div_last;
    logic left_zero;
  } sts_t;

endpackage

// File: rtl/dcs_if.sv
// Valid/ready channel interfaces for the request, frame and config ports.
// Depends on dcs_pkg for the payload widths.
interface dcs_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [dcs_pkg::ADDR_W-1:0] byte_address;
  logic [dcs_pkg::LEN_W-1:0]  request_length;

  modport source (output valid, kind, byte_address, request_length, input ready);
  modport sink   (input valid, kind, byte_address, request_length, output ready);
endinterface

interface dcs_out_if;
  logic                      valid;
  logic                      ready;
  logic [dcs_pkg::STS_W-1:0]  status;
  logic [dcs_pkg::OP_W-1:0]   opcode;
  logic [dcs_pkg::ADDR_W-1:0] address_field;
  logic [dcs_pkg::LEN_W-1:0]  data_offset;
  logic [dcs_pkg::LEN_W-1:0]  data_count;
  logic                      dummy_byte;
  logic [dcs_pkg::LEN_W-1:0]  done_length;
  logic                      is_last;

  modport source (output valid, status, opcode, address_field, data_offset, data_count,
                  dummy_byte, done_length, is_last, input ready);
  modport sink   (input valid, status, opcode, address_field, data_offset, data_count,
                  dummy_byte, done_length, is_last, output ready);
endinterface

interface dcs_cfg_if;
  logic valid;
  logic ready;
  logic page_mode;

  modport source (output valid, page_mode, input ready);
  modport sink   (input valid, page_mode, output ready);
endinterface

// File: rtl/dcs_datapath.sv
// Datapath: request registers, range check and truncation, reciprocal page
// divider, page walk counters, refresh pointer and the frame output register.
// Depends on dcs_pkg and dcs_out_if.
module dcs_datapath #(
  parameter int FLASH_PAGES = dcs_pkg::DCS_FLASH_PAGES,
  parameter int MAX_LENGTH  = dcs_pkg::DCS_MAX_LENGTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_kind,
  input  logic [dcs_pkg::ADDR_W-1:0] in_byte_address,
  input  logic [dcs_pkg::LEN_W-1:0]  in_request_length,
  input  logic                       cfg_write,
  input  logic                       cfg_page_mode,
  input  dcs_pkg::cmd_t              cmd,
  output dcs_pkg::sts_t              sts,
  dcs_out_if.source                  out_ch
);

  localparam int PAGE_W = $clog2(FLASH_PAGES);
  localparam int DW     = dcs_pkg::ADDR_W + 1;
  localparam int QW     = 37;
  localparam int QSH    = 23;
  localparam logic [DW-1:0] SIZE_1024 = DW'(1024 * FLASH_PAGES);
  localparam logic [DW-1:0] SIZE_1056 = DW'(1056 * FLASH_PAGES);
  localparam logic [dcs_pkg::LEN_W-1:0] MAX_LEN = dcs_pkg::LEN_W'(MAX_LENGTH);
  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(FLASH_PAGES - 1);
  // ceil(2^23 / 33): exact quotient for every address below the flash end
  localparam logic [17:0] RECIP_33 = 18'd254201;

  // Flash address of the first byte of a page
  function automatic logic [dcs_pkg::ADDR_W-1:0] page_addr(logic [PAGE_W-1:0] pg,
                                                           logic mode);
    logic [dcs_pkg::ADDR_W-1:0] a;
    if (mode) a = dcs_pkg::ADDR_W'({pg, 10'b0});
    else      a = dcs_pkg::ADDR_W'({pg, 11'b0});
    return a;
  endfunction

  logic                              page_mode_r;
  logic [PAGE_W-1:0]                 refresh_r;
  logic                              kind_r;
  logic [dcs_pkg::ADDR_W-1:0]        addr_r;
  logic [dcs_pkg::LEN_W-1:0]         len_r;
  logic [dcs_pkg::LEN_W-1:0]         left_r;
  logic [dcs_pkg::LEN_W-1:0]         doff_r;
  logic [dcs_pkg::ADDR_W-1:0]        rem_r;
  logic [PAGE_W-1:0]                 quo_r;
  logic                              cnt_r;

  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [dcs_pkg::STS_W-1:0]         status_r;
  logic [dcs_pkg::STS_W-1:0]         status_nxt;
  logic [dcs_pkg::OP_W-1:0]          opcode_r;
  logic [dcs_pkg::OP_W-1:0]          opcode_nxt;
  logic [dcs_pkg::ADDR_W-1:0]        afield_r;
  logic [dcs_pkg::ADDR_W-1:0]        afield_nxt;
  logic [dcs_pkg::LEN_W-1:0]         data_off_r;
  logic [dcs_pkg::LEN_W-1:0]         data_off_nxt;
  logic [dcs_pkg::LEN_W-1:0]         data_cnt_r;
  logic [dcs_pkg::LEN_W-1:0]         data_cnt_nxt;
  logic                              dummy_r;
  logic                              dummy_nxt;
  logic [dcs_pkg::LEN_W-1:0]         done_r;
  logic [dcs_pkg::LEN_W-1:0]         done_nxt;
  logic                              last_r;
  logic                              last_nxt;

  logic [dcs_pkg::POFF_W-1:0]        psz;
  logic [DW-1:0]                     size;
  logic [DW-1:0]                     avail;
  logic [QW-1:0]                     q_prod;
  logic [PAGE_W-1:0]                 q_calc;
  logic [dcs_pkg::ADDR_W-1:0]        pg_start;
  logic                              bad_addr;
  logic                              trunc;
  logic [dcs_pkg::LEN_W-1:0]         len_in_sat;
  logic [dcs_pkg::LEN_W-1:0]         len_trunc;
  logic [dcs_pkg::POFF_W-1:0]        room;
  logic [dcs_pkg::LEN_W-1:0]         chunk;
  logic [dcs_pkg::ADDR_W-1:0]        read_addr;
  logic                              out_free;

  // Size, range check and truncation
  assign psz        = page_mode_r ? dcs_pkg::PSZ_1024 : dcs_pkg::PSZ_1056;
  assign size       = page_mode_r ? SIZE_1024 : SIZE_1056;
  assign bad_addr   = {1'b0, addr_r} >= size;
  assign avail      = size - {1'b0, addr_r};
  assign trunc      = kind_r && !bad_addr && (DW'(len_r) > avail);
  assign len_trunc  = trunc ? avail[dcs_pkg::LEN_W-1:0] : len_r;
  assign len_in_sat = (in_request_length > MAX_LEN) ? MAX_LEN : in_request_length;

  // Page number: a shift for 1024-byte pages, (addr >> 5) / 33 by reciprocal
  // multiply for 1056-byte pages
  assign q_prod = QW'(addr_r[dcs_pkg::ADDR_W-1:5]) * QW'(RECIP_33);
  assign q_calc = page_mode_r ? addr_r[10 +: PAGE_W] : q_prod[QSH +: PAGE_W];

  // First byte of the page held in quo_r
  assign pg_start = dcs_pkg::ADDR_W'({quo_r, 10'b0}) +
                    (page_mode_r ? '0 : dcs_pkg::ADDR_W'({quo_r, 5'b0}));

  // Bytes that fit in the current page
  assign room  = psz - rem_r[dcs_pkg::POFF_W-1:0];
  assign chunk = (left_r >= dcs_pkg::LEN_W'(room)) ? dcs_pkg::LEN_W'(room) : left_r;

  assign read_addr = page_mode_r ? addr_r
                   : (dcs_pkg::ADDR_W'({quo_r, 11'b0}) |
                      dcs_pkg::ADDR_W'(rem_r[dcs_pkg::POFF_W-1:0]));

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    sts.out_free  = out_free;
    sts.bad_addr  = bad_addr;
    sts.empty_len = (len_r == '0);
    sts.is_write  = kind_r;
    sts.div_last  = (cnt_r == 1'b0);
    sts.left_zero = (left_r == '0);
  end

  // Hold the page mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_mode_r <= 1'b0;
    end else if (cfg_write) begin
      page_mode_r <= cfg_page_mode;
    end
  end

  // Advance the refresh pointer on each refresh frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_r <= '0;
    end else if (cmd.emit && cmd.frame == dcs_pkg::FRM_REFRESH) begin
      refresh_r <= (refresh_r == LAST_PAGE) ? '0 : refresh_r + 1'b1;
    end
  end

  // Request capture, two-step divide and page walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      addr_r <= in_byte_address;
      len_r  <= len_in_sat;
    end
    if (cmd.check) begin
      len_r  <= len_trunc;
      left_r <= len_trunc;
      doff_r <= '0;
      cnt_r  <= 1'b1;
    end
    if (cmd.div_step) begin
      if (cnt_r) quo_r <= q_calc;
      else       rem_r <= addr_r - pg_start;
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.emit && cmd.frame == dcs_pkg::FRM_WRITE) begin
      left_r <= left_r - chunk;
      doff_r <= doff_r + chunk;
    end
    if (cmd.emit && cmd.frame == dcs_pkg::FRM_PROG) begin
      quo_r <= quo_r + 1'b1;
      rem_r <= '0;
    end
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)          out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  // Build the frame for the current command
  always_comb begin
    status_nxt   = dcs_pkg::STS_OK;
    opcode_nxt   = dcs_pkg::OP_NONE;
    afield_nxt   = '0;
    data_off_nxt = '0;
    data_cnt_nxt = '0;
    dummy_nxt    = 1'b0;
    done_nxt     = '0;
    last_nxt     = 1'b0;
    unique case (cmd.frame)
      dcs_pkg::FRM_STATUS: begin
        status_nxt = bad_addr ? dcs_pkg::STS_RANGE : dcs_pkg::STS_EMPTY;
        last_nxt   = 1'b1;
      end
      dcs_pkg::FRM_READ: begin
        opcode_nxt   = dcs_pkg::OP_FAST_READ;
        afield_nxt   = read_addr;
        data_cnt_nxt = len_r;
        dummy_nxt    = 1'b1;
        done_nxt     = len_r;
        last_nxt     = 1'b1;
      end
      dcs_pkg::FRM_PRE: begin
        opcode_nxt = dcs_pkg::OP_PAGE_TO_B;
        afield_nxt = page_addr(quo_r, page_mode_r);
      end
      dcs_pkg::FRM_WRITE: begin
        opcode_nxt   = dcs_pkg::OP_BUF_WRITE;
        afield_nxt   = dcs_pkg::ADDR_W'(rem_r[dcs_pkg::POFF_W-1:0]);
        data_off_nxt = doff_r;
        data_cnt_nxt = chunk;
      end
      dcs_pkg::FRM_PROG: begin
        opcode_nxt = dcs_pkg::OP_B_TO_PAGE;
        afield_nxt = page_addr(quo_r, page_mode_r);
      end
      dcs_pkg::FRM_REFRESH: begin
        opcode_nxt = dcs_pkg::OP_REFRESH;
        afield_nxt = page_addr(refresh_r, page_mode_r);
        done_nxt   = len_r;
        last_nxt   = 1'b1;
      end
      default: begin
        last_nxt = 1'b1;
      end
    endcase
  end

  // Load one frame into the output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status_r   <= status_nxt;
      opcode_r   <= opcode_nxt;
      afield_r   <= afield_nxt;
      data_off_r <= data_off_nxt;
      data_cnt_r <= data_cnt_nxt;
      dummy_r    <= dummy_nxt;
      done_r     <= done_nxt;
      last_r     <= last_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.opcode        = opcode_r;
  assign out_ch.address_field = afield_r;
  assign out_ch.data_offset   = data_off_r;
  assign out_ch.data_count    = data_cnt_r;
  assign out_ch.dummy_byte    = dummy_r;
  assign out_ch.done_length   = done_r;
  assign out_ch.is_last       = last_r;

  // Never overwrite a frame that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("frame loaded over a pending beat");

  // Divider leaves an in-page offset before each buffer write
  a_rem_in_page: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.frame == dcs_pkg::FRM_WRITE) |-> ({1'b0, rem_r} < DW'(psz)))
    else $error("page offset not below page size");

  // Buffer write always moves at least one byte
  a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.frame == dcs_pkg::FRM_WRITE) |-> (chunk != '0))
    else $error("empty buffer write frame");

endmodule

// File: rtl/dcs_ctrl.sv
// Controller state machine: request handshake, check, divide and the
// frame-by-frame walk over the pages of a write.
// Depends on dcs_pkg.
module dcs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dcs_pkg::sts_t sts,
  output dcs_pkg::cmd_t cmd
);

  dcs_pkg::state_t state_r;
  dcs_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= dcs_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.check    = 1'b0;
    cmd.div_step = 1'b0;
    cmd.emit     = 1'b0;
    cmd.frame    = dcs_pkg::FRM_STATUS;
    unique case (state_r)
      dcs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = dcs_pkg::ST_CHECK;
        end
      end
      dcs_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts.bad_addr || (sts.is_write && sts.empty_len)) state_nxt = dcs_pkg::ST_STATUS;
        else                                                state_nxt = dcs_pkg::ST_DIVIDE;
      end
      dcs_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = sts.is_write ? dcs_pkg::ST_PRE : dcs_pkg::ST_READ;
      end
      dcs_pkg::ST_STATUS: begin
        cmd.frame = dcs_pkg::FRM_STATUS;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = dcs_pkg::ST_IDLE;
        end
      end
      dcs_pkg::ST_READ: begin
        cmd.frame = dcs_pkg::FRM_READ;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = dcs_pkg::ST_IDLE;
        end
      end
      dcs_pkg::ST_PRE: begin
        cmd.frame = dcs_pkg::FRM_PRE;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = dcs_pkg::ST_WRITE;
        end
      end
      dcs_pkg::ST_WRITE: begin
        cmd.frame = dcs_pkg::FRM_WRITE;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = dcs_pkg::ST_PROG;
        end
      end
      dcs_pkg::ST_PROG: begin
        cmd.frame = dcs_pkg::FRM_PROG;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.left_zero ? dcs_pkg::ST_REFRESH : dcs_pkg::ST_PRE;
        end
      end
      dcs_pkg::ST_REFRESH: begin
        cmd.frame = dcs_pkg::FRM_REFRESH;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = dcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dcs_pkg::ST_IDLE;
      end
    endcase
  end

  // An accepted request always goes through the check step next
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == dcs_pkg::ST_CHECK))
    else $error("accepted request skipped check");

  // Divider ends after its last step
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dcs_pkg::ST_DIVIDE && sts.div_last) |=> (state_r != dcs_pkg::ST_DIVIDE))
    else $error("divider ran past its last step");

  // Page walk starts only for a write that passed the check
  a_walk_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dcs_pkg::ST_PRE) |-> (sts.is_write && !sts.bad_addr))
    else $error("page walk for a read or out-of-range request");

endmodule

// File: rtl/dataflash_command_sequencer.sv
// A read or write shows its first frame after the request beat, the check step,
// two divide steps and the load of the output register; range and empty-write
// status beats show after the check step and the load. Further frames of a write
// follow one per cycle while taken. One request is handled at a time; the next is
// accepted the cycle after the last frame of the previous one loads.
// Reset: selects 1056-byte pages, clears the refresh page, drops all valids.
module dataflash_command_sequencer #(
  parameter int FLASH_PAGES = dcs_pkg::DCS_FLASH_PAGES,
  parameter int MAX_LENGTH  = dcs_pkg::DCS_MAX_LENGTH
) (
  input logic        clk,
  input logic        rst_n,
  dcs_in_if.sink     in_ch,
  dcs_out_if.source  out_ch,
  dcs_cfg_if.sink    cfg_ch
);

  dcs_pkg::cmd_t cmd;
  dcs_pkg::sts_t sts;
  logic          in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  dcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dcs_datapath #(
    .FLASH_PAGES (FLASH_PAGES),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_kind           (in_ch.kind),
    .in_byte_address   (in_ch.byte_address),
    .in_request_length (in_ch.request_length),
    .cfg_write         (cfg_ch.valid),
    .cfg_page_mode     (cfg_ch.page_mode),
    .cmd               (cmd),
    .sts               (sts),
    .out_ch            (out_ch)
  );

endmodule
